[hdl/wsfd_pkg.sv]
// wsfd_pkg: shared types and constants for the websocket frame decoder
// no dependencies; used by the interfaces and every module in hdl/

package wsfd_pkg;

  // parser phase, unused codes fall back to idle behaviour
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT     = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DISCARD = 3'd5
  } phase_e;

  // result kind
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_e;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 32;
  localparam int unsigned CountW = 4;

  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;

  localparam logic [CountW-1:0] Ext16Bytes = 4'd2;
  localparam logic [CountW-1:0] Ext64Bytes = 4'd8;
  localparam logic [CountW-1:0] KeyBytes   = 4'd4;
  // extended length counts above this are the upper 32 bits of a 64-bit length
  localparam logic [CountW-1:0] UpperHalf  = 4'd4;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data;
    logic              fin;
    logic [3:0]        opcode;
    logic              masked;
    logic [LenW-1:0]   payload_len;
    logic              last;
  } res_t;

endpackage

[hdl/wsfd_if.sv]
// wsfd_rx_if, wsfd_res_if: valid/ready channels of the frame decoder
// depends on wsfd_pkg

interface wsfd_rx_if;
  logic                      valid;
  logic                      ready;
  logic [wsfd_pkg::ByteW-1:0] rx_byte;
  logic                      start_frame;

  modport source (output valid, output rx_byte, output start_frame, input ready);
  modport sink   (input valid, input rx_byte, input start_frame, output ready);
endinterface

interface wsfd_res_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [wsfd_pkg::ByteW-1:0] data;
  logic                      fin;
  logic [3:0]                opcode;
  logic                      masked;
  logic [wsfd_pkg::LenW-1:0] payload_len;
  logic                      last;

  modport source (output valid, output kind, output data, output fin, output opcode,
                  output masked, output payload_len, output last, input ready);
  modport sink   (input valid, input kind, input data, input fin, input opcode,
                  input masked, input payload_len, input last, output ready);
endinterface

[hdl/wsfd_parse.sv]
// wsfd_parse: header/payload state machine, one byte per step
// depends on wsfd_pkg

module wsfd_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [wsfd_pkg::ByteW-1:0] byte_i,
  input  logic                       start_i,
  output logic                       res_valid_o,
  output wsfd_pkg::res_t             res_o
);

  wsfd_pkg::phase_e               phase_q, phase_d;
  logic [wsfd_pkg::CountW-1:0]    hcnt_q, hcnt_d, hcnt_dec;
  logic                           fin_q, fin_d;
  logic [3:0]                     opcode_q, opcode_d;
  logic                           mask_q, mask_d;
  logic [wsfd_pkg::LenW-1:0]      len_q, len_d;
  logic [31:0]                    key_q, key_d;
  logic [wsfd_pkg::LenW-1:0]      left_q, left_d;
  logic [1:0]                     kpos_q, kpos_d;

  logic                           do_finish;
  logic [wsfd_pkg::LenW-1:0]      finish_len;
  logic [wsfd_pkg::ByteW-1:0]     key_byte;

  always_comb begin
    case (kpos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign hcnt_dec = hcnt_q - 4'd1;

  always_comb begin
    phase_d     = phase_q;
    hcnt_d      = hcnt_q;
    fin_d       = fin_q;
    opcode_d    = opcode_q;
    mask_d      = mask_q;
    len_d       = len_q;
    key_d       = key_q;
    left_d      = left_q;
    kpos_d      = kpos_q;
    do_finish   = 1'b0;
    finish_len  = len_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (start_i) begin
      fin_d    = byte_i[7];
      opcode_d = byte_i[3:0];
      mask_d   = 1'b0;
      len_d    = '0;
      key_d    = '0;
      left_d   = '0;
      kpos_d   = '0;
      hcnt_d   = '0;
      phase_d  = wsfd_pkg::PH_LEN;
    end else begin
      case (phase_q)
        wsfd_pkg::PH_LEN: begin
          mask_d = byte_i[7];
          len_d  = '0;
          if (byte_i[6:0] == wsfd_pkg::LenExt16) begin
            hcnt_d  = wsfd_pkg::Ext16Bytes;
            phase_d = wsfd_pkg::PH_EXT;
          end else if (byte_i[6:0] == wsfd_pkg::LenExt64) begin
            hcnt_d  = wsfd_pkg::Ext64Bytes;
            phase_d = wsfd_pkg::PH_EXT;
          end else begin
            len_d = {{(wsfd_pkg::LenW-7){1'b0}}, byte_i[6:0]};
            if (byte_i[7]) begin
              hcnt_d  = wsfd_pkg::KeyBytes;
              phase_d = wsfd_pkg::PH_KEY;
            end else begin
              do_finish  = 1'b1;
              finish_len = {{(wsfd_pkg::LenW-7){1'b0}}, byte_i[6:0]};
            end
          end
        end
        wsfd_pkg::PH_EXT: begin
          if (hcnt_q > wsfd_pkg::UpperHalf && byte_i != '0) begin
            // length beyond 32 bits
            phase_d     = wsfd_pkg::PH_DISCARD;
            hcnt_d      = '0;
            res_valid_o = 1'b1;
            res_o.kind  = wsfd_pkg::KIND_DISCARD;
            res_o.fin   = fin_q;
            res_o.opcode = opcode_q;
            res_o.masked = mask_q;
          end else begin
            if (hcnt_q <= wsfd_pkg::UpperHalf) begin
              len_d = {len_q[wsfd_pkg::LenW-9:0], byte_i};
            end
            hcnt_d = hcnt_dec;
            if (hcnt_dec == '0) begin
              if (mask_q) begin
                hcnt_d  = wsfd_pkg::KeyBytes;
                phase_d = wsfd_pkg::PH_KEY;
              end else begin
                do_finish  = 1'b1;
                finish_len = len_d;
              end
            end
          end
        end
        wsfd_pkg::PH_KEY: begin
          key_d  = {key_q[23:0], byte_i};
          hcnt_d = hcnt_dec;
          if (hcnt_dec == '0) begin
            do_finish  = 1'b1;
            finish_len = len_q;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          res_valid_o       = 1'b1;
          res_o.kind        = wsfd_pkg::KIND_PAYLOAD;
          res_o.data        = byte_i ^ (mask_q ? key_byte : '0);
          res_o.fin         = fin_q;
          res_o.opcode      = opcode_q;
          res_o.masked      = mask_q;
          res_o.payload_len = len_q;
          res_o.last        = (left_q == 32'd1);
          kpos_d            = kpos_q + 2'd1;
          left_d            = left_q - 32'd1;
          if (left_q == 32'd1) begin
            phase_d = wsfd_pkg::PH_IDLE;
          end
        end
        default: begin
        end
      endcase

      if (do_finish) begin
        if (!mask_d) begin
          key_d = '0;
        end
        kpos_d       = '0;
        left_d       = finish_len;
        res_valid_o  = 1'b1;
        res_o.kind   = wsfd_pkg::KIND_HEADER;
        res_o.fin    = fin_q;
        res_o.opcode = opcode_q;
        res_o.masked = mask_d;
        if (finish_len == '0) begin
          phase_d    = wsfd_pkg::PH_IDLE;
          res_o.last = 1'b1;
        end else begin
          phase_d           = wsfd_pkg::PH_PAYLOAD;
          res_o.payload_len = finish_len;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfd_pkg::PH_IDLE;
      hcnt_q   <= '0;
      fin_q    <= 1'b0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      len_q    <= '0;
      key_q    <= '0;
      left_q   <= '0;
      kpos_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      hcnt_q   <= hcnt_d;
      fin_q    <= fin_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      key_q    <= key_d;
      left_q   <= left_d;
      kpos_q   <= kpos_d;
    end
  end

endmodule

[hdl/wsfd_out_buf.sv]
// wsfd_out_buf: result register with one skid entry
// depends on wsfd_pkg

module wsfd_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wsfd_pkg::res_t  res_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            ready_i,
  output wsfd_pkg::res_t  res_o
);

  logic           main_valid_q;
  logic           skid_valid_q;
  wsfd_pkg::res_t main_q;
  wsfd_pkg::res_t skid_q;

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign res_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_valid_q && !ready_i) begin
      if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      main_valid_q <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_valid_q && !ready_i) begin
      if (push_i) begin
        skid_q <= res_i;
      end
    end else if (skid_valid_q) begin
      main_q <= skid_q;
    end else if (push_i) begin
      main_q <= res_i;
    end
  end

endmodule

[hdl/websocket_frame_decoder_top.sv]
// websocket_frame_decoder_top: byte-serial websocket frame header parser and unmasker
// an accepted byte waits in the input reg; its result is held in the result reg
// throughput: one byte per cycle while the skid entry in wsfd_out_buf is free
// a stalled result sink is absorbed by one skid entry before the input side holds off
// reset (rst_ni, asynchronous, active low) empties both stages and returns the parser to idle
// depends on wsfd_pkg, wsfd_if, wsfd_parse, wsfd_out_buf

module websocket_frame_decoder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  wsfd_rx_if.sink           rx_i,
  wsfd_res_if.source        res_o
);

  // input register: one received byte and its start-of-frame flag
  logic                       in_valid_q;
  logic [wsfd_pkg::ByteW-1:0] in_byte_q;
  logic                       in_start_q;

  // parser to result buffer
  logic                       step;
  logic                       parse_valid;
  wsfd_pkg::res_t             parse_res;
  logic                       buf_ready;
  wsfd_pkg::res_t             out_res;

  // the held byte is parsed once the result buffer has room for whatever it yields
  assign step       = in_valid_q && buf_ready;
  // take a new beat whenever the input register is empty or drains this cycle
  assign rx_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q  <= rx_i.rx_byte;
      in_start_q <= rx_i.start_frame;
    end
  end

  // header decode, length assembly, key capture and unmasking
  wsfd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .start_i     (in_start_q),
    .res_valid_o (parse_valid),
    .res_o       (parse_res)
  );

  // result register plus skid entry so a stall does not stop the byte stream at once
  wsfd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step && parse_valid),
    .res_i   (parse_res),
    .ready_o (buf_ready),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (out_res)
  );

  // unpack the result beat onto the channel
  assign res_o.kind        = out_res.kind;
  assign res_o.data        = out_res.data;
  assign res_o.fin         = out_res.fin;
  assign res_o.opcode      = out_res.opcode;
  assign res_o.masked      = out_res.masked;
  assign res_o.payload_len = out_res.payload_len;
  assign res_o.last        = out_res.last;

endmodule

[sim/tb.sv]
// tb: self-checking testbench for websocket_frame_decoder_top
// a table of directed frames, then random frames, checked against hand-written results or an in-bench decoder
// depends on wsfd_pkg, wsfd_if and the top level in hdl/

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfd_pkg::*;

  localparam int unsigned LiveBeats   = 400;      // random beats that the parser really consumes
  localparam int unsigned MaxGap      = 19;       // longest idle or stall drawn per beat
  localparam int unsigned LongHold    = 300;      // sink hold-off, long enough to back up the input
  localparam int unsigned DrainCycles = 8;        // input and result registers plus skid entry, with margin
  localparam int unsigned CycleLimit  = 400_000;  // far above the slowest legal run

  // one input beat: received byte and its start-of-frame flag
  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             s;
  } rx_beat_t;

  // directed row: typed rows carry the result (or its absence) written out by hand,
  // the others take whatever the decoder below works out
  typedef struct {
    rx_beat_t beat;
    bit       typed;
    bit       has_res;
    res_t     res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  wsfd_rx_if  rx_if ();
  wsfd_res_if res_if ();

  websocket_frame_decoder_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // ---------------------------------------------------------------------------
  // frame decoder mirror: parser phase, header fields, key and payload position
  // ---------------------------------------------------------------------------
  phase_e           ph;
  logic [CountW-1:0] hdr_left;     // extended-length or key bytes still to come
  logic             frm_fin;
  logic [3:0]       frm_op;
  logic             frm_mask;
  logic [LenW-1:0]  frm_len;
  logic [31:0]      key_word;     // first key byte sits in the top byte
  logic [LenW-1:0]  bytes_due;    // payload bytes still to come
  logic [1:0]       key_idx;

  res_t        results_due[$];    // decoded results not yet seen on the output
  rx_beat_t    frame_q[$];        // beats of the frame being sent
  dir_row_t    dir_tab[$];

  int unsigned mismatches;
  int unsigned live_beats;
  int unsigned hold_requests;
  int unsigned cycles;
  bit          in_long_hold;      // set by the sink while it holds off
  bit          tx_calm;           // sender stretch with no idling

  function automatic res_t make_res(input kind_e k, input logic [ByteW-1:0] d,
                                    input logic [LenW-1:0] len, input logic last);
    res_t r;
    r.kind        = k;
    r.data        = d;
    r.fin         = frm_fin;
    r.opcode      = frm_op;
    r.masked      = frm_mask;
    r.payload_len = len;
    r.last        = last;
    return r;
  endfunction

  // header complete: report it and move on to payload, or straight back to idle
  function automatic res_t close_header();
    if (!frm_mask) key_word = '0;
    key_idx   = '0;
    bytes_due = frm_len;
    if (frm_len == '0) begin
      ph = PH_IDLE;
      return make_res(KIND_HEADER, 8'h00, '0, 1'b1);
    end
    ph = PH_PAYLOAD;
    return make_res(KIND_HEADER, 8'h00, frm_len, 1'b0);
  endfunction

  // advances the mirror by one byte; returns 1 when the byte yields a result
  function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic s, output res_t r);
    logic [ByteW-1:0] k;
    r = '0;
    // a start always opens a new frame, whatever was going on
    if (s) begin
      frm_fin   = b[7];
      frm_op    = b[3:0];
      frm_mask  = 1'b0;
      frm_len   = '0;
      key_word  = '0;
      bytes_due = '0;
      key_idx   = '0;
      hdr_left  = '0;
      ph        = PH_LEN;
      return 1'b0;
    end
    case (ph)
      PH_LEN: begin
        frm_mask = b[7];
        frm_len  = '0;
        if (b[6:0] == LenExt16) begin
          hdr_left = Ext16Bytes;
          ph       = PH_EXT;
          return 1'b0;
        end
        if (b[6:0] == LenExt64) begin
          hdr_left = Ext64Bytes;
          ph       = PH_EXT;
          return 1'b0;
        end
        frm_len = {25'd0, b[6:0]};
        if (frm_mask) begin
          hdr_left = KeyBytes;
          ph       = PH_KEY;
          return 1'b0;
        end
        r = close_header();
        return 1'b1;
      end
      PH_EXT: begin
        // upper half of a 64-bit length must be zero, else the frame is dropped
        if (hdr_left > UpperHalf) begin
          if (b != 8'h00) begin
            ph       = PH_DISCARD;
            hdr_left = '0;
            r        = make_res(KIND_DISCARD, 8'h00, '0, 1'b0);
            return 1'b1;
          end
        end else begin
          frm_len = {frm_len[LenW-9:0], b};
        end
        hdr_left = hdr_left - 1'b1;
        if (hdr_left != '0) return 1'b0;
        if (frm_mask) begin
          hdr_left = KeyBytes;
          ph       = PH_KEY;
          return 1'b0;
        end
        r = close_header();
        return 1'b1;
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        hdr_left = hdr_left - 1'b1;
        if (hdr_left != '0) return 1'b0;
        r = close_header();
        return 1'b1;
      end
      PH_PAYLOAD: begin
        k = frm_mask ? key_word[8*(3-key_idx) +: 8] : 8'h00;
        r = make_res(KIND_PAYLOAD, b ^ k, frm_len, bytes_due == 1);
        key_idx   = key_idx + 1'b1;
        bytes_due = bytes_due - 1'b1;
        if (bytes_due == '0) ph = PH_IDLE;
        return 1'b1;
      end
      // idle, discarding and unused codes swallow the byte
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------
  function automatic void row_model(input logic [ByteW-1:0] b, input logic s);
    dir_row_t row;
    row.beat    = {b, s};
    row.typed   = 1'b0;
    row.has_res = 1'b0;
    row.res     = '0;
    dir_tab.push_back(row);
  endfunction

  function automatic void row_quiet(input logic [ByteW-1:0] b, input logic s);
    dir_row_t row;
    row.beat    = {b, s};
    row.typed   = 1'b1;
    row.has_res = 1'b0;
    row.res     = '0;
    dir_tab.push_back(row);
  endfunction

  function automatic void row_result(input logic [ByteW-1:0] b, input kind_e k, input logic fin,
                                     input logic [3:0] op, input logic m,
                                     input logic [LenW-1:0] len, input logic last);
    dir_row_t row;
    row.beat            = {b, 1'b0};
    row.typed           = 1'b1;
    row.has_res         = 1'b1;
    row.res.kind        = k;
    row.res.data        = 8'h00;
    row.res.fin         = fin;
    row.res.opcode      = op;
    row.res.masked      = m;
    row.res.payload_len = len;
    row.res.last        = last;
    dir_tab.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // random frame builder
  // ---------------------------------------------------------------------------
  function automatic void add_beat(input logic [ByteW-1:0] b, input logic s);
    rx_beat_t bt;
    bt.b = b;
    bt.s = s;
    frame_q.push_back(bt);
  endfunction

  // mostly well-formed frames with random content; the rest are truncated frames,
  // oversized 64-bit lengths, huge lengths cut short and stray bytes
  function automatic void build_frame();
    int unsigned sel;
    int unsigned pick;
    int unsigned n;
    int unsigned cut;
    logic        m;
    logic [LenW-1:0] len;
    frame_q.delete();
    sel = $urandom_range(0, 99);
    // stray bytes without a start
    if (sel >= 92) begin
      n = $urandom_range(1, 5);
      repeat (n) add_beat(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    m = 1'($urandom_range(0, 1));
    add_beat(8'($urandom_range(0, 255)), 1'b1);
    // nonzero upper length byte somewhere, then junk that must be ignored
    if (sel >= 77 && sel < 85) begin
      add_beat({m, LenExt64}, 1'b0);
      pick = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
        if (i < pick) add_beat(8'h00, 1'b0);
        else if (i == pick) add_beat(8'($urandom_range(1, 255)), 1'b0);
        else add_beat(8'($urandom_range(0, 255)), 1'b0);
      end
      n = $urandom_range(0, 3);
      repeat (n) add_beat(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    // huge lengths exercise every length bit; only a few payload bytes follow
    if (sel >= 85) begin
      pick = 99;
      len  = $urandom;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) len = $urandom_range(0, 12);
      else if (pick < 65) len = $urandom_range(0, 125);
      else if (pick < 85) len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 300)
                                                               : $urandom_range(0, 20);
      else len = $urandom_range(0, 30);
    end
    if (pick < 65) begin
      add_beat({m, len[6:0]}, 1'b0);
    end else if (pick < 85) begin
      add_beat({m, LenExt16}, 1'b0);
      add_beat(len[15:8], 1'b0);
      add_beat(len[7:0], 1'b0);
    end else begin
      add_beat({m, LenExt64}, 1'b0);
      repeat (4) add_beat(8'h00, 1'b0);
      add_beat(len[31:24], 1'b0);
      add_beat(len[23:16], 1'b0);
      add_beat(len[15:8], 1'b0);
      add_beat(len[7:0], 1'b0);
    end
    if (m) repeat (4) add_beat(8'($urandom_range(0, 255)), 1'b0);
    n = (sel >= 85) ? $urandom_range(1, 6) : len;
    repeat (n) add_beat(8'($urandom_range(0, 255)), 1'b0);
    // truncated frame: the next start abandons it
    if (sel >= 62 && sel < 77) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender side: idle gap, then hold the beat until it is taken
  // ---------------------------------------------------------------------------
  task automatic drive_beat(input rx_beat_t bt);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    // keep offering at full rate while the sink holds off
    gap = (tx_calm || in_long_hold) ? 0 : $urandom_range(0, MaxGap);
    repeat (gap) begin
      @(negedge clk);
      rx_if.valid <= 1'b0;
    end
    @(negedge clk);
    rx_if.valid       <= 1'b1;
    rx_if.rx_byte     <= bt.b;
    rx_if.start_frame <= bt.s;
    do @(posedge clk); while (rx_if.ready !== 1'b1);
  endtask

  task automatic offer_beat(input rx_beat_t bt);
    res_t r;
    drive_beat(bt);
    if (bt.s || ph == PH_LEN || ph == PH_EXT || ph == PH_KEY || ph == PH_PAYLOAD)
      live_beats++;
    if (decode_byte(bt.b, bt.s, r)) results_due.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // sink side checks
  // ---------------------------------------------------------------------------
  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (results_due.size() == 0) begin
      mismatches++;
      $display("%0t: result with none expected, got kind %0h data %0h len %0h",
               $time, got.kind, got.data, got.payload_len);
      return;
    end
    want = results_due.pop_front();
    cmp_field("kind",        want.kind,        got.kind);
    cmp_field("data",        want.data,        got.data);
    cmp_field("fin",         want.fin,         got.fin);
    cmp_field("opcode",      want.opcode,      got.opcode);
    cmp_field("masked",      want.masked,      got.masked);
    cmp_field("payload_len", want.payload_len, got.payload_len);
    cmp_field("last",        want.last,        got.last);
  endtask

  // ---------------------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result sink: random stalls, one long hold-off on request, check every beat
  // ---------------------------------------------------------------------------
  initial begin
    res_t        got;
    int unsigned stall;
    int unsigned holds_done;
    bit          rx_calm;
    res_if.ready = 1'b0;
    in_long_hold = 1'b0;
    mismatches   = 0;
    holds_done   = 0;
    rx_calm      = 1'b0;
    @(posedge rst_n);
    forever begin
      // long hold-off, counted here, while the sender keeps pushing
      if (holds_done != hold_requests) begin
        holds_done++;
        in_long_hold = 1'b1;
        @(negedge clk);
        res_if.ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk);
        in_long_hold = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, MaxGap);
      repeat (stall) begin
        @(negedge clk);
        res_if.ready <= 1'b0;
      end
      @(negedge clk);
      res_if.ready <= 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
      got = {res_if.kind, res_if.data, res_if.fin, res_if.opcode, res_if.masked,
             res_if.payload_len, res_if.last};
      check_result(got);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: reset, directed table, random frames, drain and verdict
  // ---------------------------------------------------------------------------
  initial begin
    res_t        r;
    bit          got_res;
    bit          paused;
    rst_n             = 1'b0;
    rx_if.valid       = 1'b0;
    rx_if.rx_byte     = '0;
    rx_if.start_frame = 1'b0;
    tx_calm           = 1'b0;
    live_beats        = 0;
    hold_requests     = 0;
    paused            = 1'b0;
    // mirror starts from the reset state, parser idle
    ph        = PH_IDLE;
    hdr_left  = '0;
    frm_fin   = 1'b0;
    frm_op    = '0;
    frm_mask  = 1'b0;
    frm_len   = '0;
    key_word  = '0;
    bytes_due = '0;
    key_idx   = '0;

    // stray byte straight after reset, parser idle
    row_quiet(8'hFF, 1'b0);
    // final text frame of length zero: header flagged last
    row_quiet(8'h81, 1'b1);
    row_result(8'h00, KIND_HEADER, 1'b1, 4'h1, 1'b0, 32'd0, 1'b1);
    // masked empty frame: key bytes still belong to the header
    row_quiet(8'h0F, 1'b1);
    row_quiet(8'h80, 1'b0);
    row_quiet(8'hDE, 1'b0);
    row_quiet(8'hAD, 1'b0);
    row_quiet(8'hBE, 1'b0);
    row_result(8'hEF, KIND_HEADER, 1'b0, 4'hF, 1'b1, 32'd0, 1'b1);
    // 64-bit length with a nonzero upper byte: frame dropped
    row_quiet(8'h82, 1'b1);
    row_quiet(8'h7F, 1'b0);
    row_quiet(8'h00, 1'b0);
    row_result(8'h01, KIND_DISCARD, 1'b1, 4'h2, 1'b0, 32'd0, 1'b0);
    // non-minimal 16-bit length of two, all-ones and all-zeros payload
    row_quiet(8'h02, 1'b1);
    row_quiet(8'h7E, 1'b0);
    row_quiet(8'h00, 1'b0);
    row_result(8'h02, KIND_HEADER, 1'b0, 4'h2, 1'b0, 32'd2, 1'b0);
    row_model(8'hFF, 1'b0);
    row_model(8'h00, 1'b0);
    // new start in mid-payload, then a byte past the end of the empty frame
    row_quiet(8'h89, 1'b1);
    row_model(8'h03, 1'b0);
    row_model(8'h11, 1'b0);
    row_quiet(8'h8A, 1'b1);
    row_result(8'h00, KIND_HEADER, 1'b1, 4'hA, 1'b0, 32'd0, 1'b1);
    row_quiet(8'h22, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      drive_beat(dir_tab[i].beat);
      got_res = decode_byte(dir_tab[i].beat.b, dir_tab[i].beat.s, r);
      if (!dir_tab[i].typed) begin
        if (got_res) results_due.push_back(r);
      end else if (dir_tab[i].has_res) begin
        results_due.push_back(dir_tab[i].res);
      end
    end

    // random frames until enough beats have reached the parser
    while (live_beats < LiveBeats) begin
      build_frame();
      // sink backs up for a long stretch while beats keep coming
      if (hold_requests == 0 && live_beats >= LiveBeats / 4) hold_requests++;
      // sender stands still until everything has come out
      if (!paused && live_beats >= LiveBeats / 2) begin
        paused = 1'b1;
        while (results_due.size() != 0) @(posedge clk);
      end
      foreach (frame_q[i]) offer_beat(frame_q[i]);
    end
    @(negedge clk) rx_if.valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/wsfd_pkg.sv
hdl/wsfd_if.sv
hdl/wsfd_parse.sv
hdl/wsfd_out_buf.sv
hdl/websocket_frame_decoder_top.sv
sim/tb.sv
